[hw/rtl/qwo_pkg.sv]
`timescale 1ns / 1ps

package qwo_pkg;

  localparam int DEF_CORDIC_ITERS = 16;
  localparam int DEF_COUNT_WIDTH  = 16;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_CPR      = 2'd0;
  localparam logic [1:0] REG_DIAMETER = 2'd1;
  localparam logic [1:0] REG_BASE     = 2'd2;

  localparam logic [15:0] CPR_RST      = 16'd1000;
  localparam logic [19:0] DIAMETER_RST = 20'd100000;
  localparam logic [21:0] BASE_RST     = 22'd200000;

  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 64;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int ZW = 36;
  localparam logic [63:0]          PI_Q29      = 64'd1686629713;
  localparam logic [32:0]          TWO_PI_DIV  = 33'd6746518852;
  localparam logic signed [ZW-1:0] Z_PI        = 36'sd3373259426;
  localparam logic signed [ZW-1:0] Z_HALF_PI   = 36'sd1686629713;
  localparam logic signed [ZW-1:0] Z_TWO_PI    = 36'sd6746518852;
  localparam logic signed [ZW-1:0] Z_GAIN      = 36'sd652032874;
  localparam logic [32:0]          MS_PER_S    = 33'd1000;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  typedef struct packed {
    logic        func;
    logic        right_a;
    logic        right_b;
    logic        left_a;
    logic        left_b;
    logic [31:0] elapsed_ms;
  } in_t;

  typedef struct packed {
    logic signed [31:0] right_dist_um;
    logic signed [31:0] left_dist_um;
    logic signed [31:0] delta_heading;
    logic signed [31:0] heading;
    logic signed [31:0] turn_rate;
    logic signed [31:0] disp_x_um;
    logic signed [31:0] disp_y_um;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic               zero_interval;
  } out_t;

  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [63:0] a;
    logic [32:0] b;
  } su_ctl_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] res;
    logic [32:0] rem;
  } su_sts_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Applies a sign to a magnitude and saturates to the 32-bit signed range.
  function automatic logic [31:0] sat32(input logic neg, input logic [63:0] q);
    logic [31:0] r;
    if (neg) begin
      r = (q >= 64'h8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    end else begin
      r = (q >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/quadrature_wheel_odometry.sv]
`timescale 1ns / 1ps
// Pin samples are taken in every cycle, also while an update is in work; the counters
// change in the cycle after the beat.
// An update runs all its products and quotients one after another on the one shared bit-serial
// multiply/divide unit. It skips the speed steps when elapsed is zero, and the remaining wheel
// steps when a wheel distance saturates.
// A further update is held off until the previous one has finished.
// Synchronous active-low reset clears counters, heading, handshakes and loads register defaults.
module quadrature_wheel_odometry #(
  parameter int CORDIC_ITERS = qwo_pkg::DEF_CORDIC_ITERS,
  parameter int COUNT_WIDTH  = qwo_pkg::DEF_COUNT_WIDTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  qwo_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output qwo_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_idx,
  input  logic [21:0]   cfg_data
);

  localparam int ITW = $clog2(CORDIC_ITERS);
  localparam int CW  = COUNT_WIDTH;
  localparam int ZW  = qwo_pkg::ZW;

  localparam logic [1:0] V_TURN = 2'd0;
  localparam logic [1:0] V_X    = 2'd1;
  localparam logic [1:0] V_Y    = 2'd2;

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_WMUL1 = 18'h00002,
    S_WDIV1 = 18'h00004,
    S_WMUL2 = 18'h00008,
    S_WMUL3 = 18'h00010,
    S_WDIV2 = 18'h00020,
    S_WFIN  = 18'h00040,
    S_DTH   = 18'h00080,
    S_RED   = 18'h00100,
    S_WRAP  = 18'h00200,
    S_FOLD  = 18'h00400,
    S_COR   = 18'h00800,
    S_MULX  = 18'h01000,
    S_MULY  = 18'h02000,
    S_HEAD  = 18'h04000,
    S_VMUL  = 18'h08000,
    S_VDIV  = 18'h10000,
    S_OUT   = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration.
  logic [15:0] cpr_r;
  logic [19:0] diam_r;
  logic [21:0] base_r;
  logic [15:0] cpr_eff;
  logic [21:0] base_eff;

  // Encoder front end.
  logic signed [CW-1:0] right_cnt_r, left_cnt_r;
  logic [3:0]           last_pins_r;
  logic                 primed_r;

  // Update datapath.
  logic signed [CW-1:0] rsnap_r, lsnap_r;
  logic [31:0]          el_r;
  logic                 w_r;
  logic                 wait_r;
  logic                 big_r;
  logic [63:0]          p_r, q_r, t1_r;
  logic [32:0]          r_r;
  logic signed [31:0]   rd_r, ld_r, dth_r, head_r, px_r, py_r, vth_r, vx_r, vy_r;
  logic                 zero_r;
  logic signed [ZW-1:0] x_r, y_r, z_r;
  logic                 flip_r;
  logic [4:0]           k_r;
  logic [ITW-1:0]       itc_r;
  logic [1:0]           v_r;
  logic                 out_valid_r;
  qwo_pkg::out_t        out_data_r;

  qwo_pkg::su_ctl_t u_ctl;
  qwo_pkg::su_sts_t u_sts;

  qwo_serial u_serial (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (u_ctl),
    .sts   (u_sts)
  );

  logic pin_beat, upd_beat;
  assign in_stall = (state_r != S_IDLE) && in_data.func;
  assign pin_beat = in_valid && !in_stall && !in_data.func;
  assign upd_beat = in_valid && !in_stall && in_data.func;

  assign cpr_eff  = (cpr_r == '0) ? 16'd1 : cpr_r;
  assign base_eff = (base_r == '0) ? 22'd1 : base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r  <= qwo_pkg::CPR_RST;
      diam_r <= qwo_pkg::DIAMETER_RST;
      base_r <= qwo_pkg::BASE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        qwo_pkg::REG_CPR:      cpr_r  <= cfg_data[15:0];
        qwo_pkg::REG_DIAMETER: diam_r <= cfg_data[19:0];
        qwo_pkg::REG_BASE:     base_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // x4 decoding: each changed pin steps its wheel by one.
  function automatic logic signed [CW-1:0] cnt_add(input logic signed [CW-1:0] c,
                                                   input logic signed [2:0] d);
    logic signed [CW+1:0] s;
    logic signed [CW-1:0] r;
    s = $signed({{2{c[CW-1]}}, c}) + $signed({{(CW - 1){d[2]}}, d});
    if (s[CW+1:CW-1] == '0 || s[CW+1:CW-1] == '1) begin
      r = s[CW-1:0];
    end else begin
      r = s[CW+1] ? {1'b1, {(CW - 1){1'b0}}} : {1'b0, {(CW - 1){1'b1}}};
    end
    return r;
  endfunction

  logic [3:0]        pins, chg;
  logic signed [2:0] dr, dl;

  always_comb begin
    pins = {in_data.left_b, in_data.left_a, in_data.right_b, in_data.right_a};
    chg  = pins ^ last_pins_r;
    dr   = 3'sd0;
    dl   = 3'sd0;
    if (chg[0]) dr = dr + ((pins[0] != pins[1]) ? 3'sd1 : -3'sd1);
    if (chg[1]) dr = dr + ((pins[0] == pins[1]) ? 3'sd1 : -3'sd1);
    if (chg[2]) dl = dl + ((pins[2] == pins[3]) ? 3'sd1 : -3'sd1);
    if (chg[3]) dl = dl + ((pins[2] != pins[3]) ? 3'sd1 : -3'sd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_cnt_r <= '0;
      left_cnt_r  <= '0;
      last_pins_r <= '0;
      primed_r    <= 1'b0;
    end else if (pin_beat) begin
      if (primed_r) begin
        right_cnt_r <= cnt_add(right_cnt_r, dr);
        left_cnt_r  <= cnt_add(left_cnt_r, dl);
      end
      last_pins_r <= pins;
      primed_r    <= 1'b1;
    end else if (upd_beat) begin
      right_cnt_r <= '0;
      left_cnt_r  <= '0;
    end
  end

  // Operand selection for the serial unit.
  logic [31:0]          cnt_mag, dth_mag, c_mag, s_mag, v_mag;
  logic signed [32:0]   diff33, sum33;
  logic [32:0]          diff_mag, sum_mag;
  logic signed [ZW-1:0] c_val, c_abs, s_abs;
  logic signed [31:0]   v_src;
  logic signed [CW-1:0] cnt_sel;
  logic                 op_state, launch;

  always_comb begin
    cnt_sel  = w_r ? lsnap_r : rsnap_r;
    cnt_mag  = qwo_pkg::mag32(32'(cnt_sel));
    dth_mag  = qwo_pkg::mag32(dth_r);
    diff33   = {rd_r[31], rd_r} - {ld_r[31], ld_r};
    sum33    = {rd_r[31], rd_r} + {ld_r[31], ld_r};
    diff_mag = diff33[32] ? (~diff33 + 33'sd1) : diff33;
    sum_mag  = sum33[32] ? (~sum33 + 33'sd1) : sum33;
    c_val    = flip_r ? -x_r : x_r;
    c_abs    = c_val[ZW-1] ? -c_val : c_val;
    s_abs    = y_r[ZW-1] ? -y_r : y_r;
    c_mag    = c_abs[31:0];
    s_mag    = s_abs[31:0];
    case (v_r)
      V_TURN:  v_src = dth_r;
      V_X:     v_src = px_r;
      default: v_src = py_r;
    endcase
    v_mag = qwo_pkg::mag32(v_src);
  end

  always_comb begin
    op_state = 1'b1;
    u_ctl.is_div = 1'b0;
    u_ctl.a = '0;
    u_ctl.b = '0;
    case (state_r)
      S_WMUL1: begin
        u_ctl.a = {32'd0, cnt_mag};
        u_ctl.b = {13'd0, diam_r};
      end
      S_WDIV1, S_WDIV2: begin
        u_ctl.is_div = 1'b1;
        u_ctl.a = p_r;
        u_ctl.b = {17'd0, cpr_eff};
      end
      S_WMUL2: begin
        u_ctl.a = qwo_pkg::PI_Q29;
        u_ctl.b = {2'd0, q_r[30:0]};
      end
      S_WMUL3: begin
        u_ctl.a = qwo_pkg::PI_Q29;
        u_ctl.b = r_r;
      end
      S_DTH: begin
        u_ctl.is_div = 1'b1;
        u_ctl.a = {15'd0, diff_mag, 16'd0} + {43'd0, base_eff[21:1]};
        u_ctl.b = {11'd0, base_eff};
      end
      S_RED: begin
        u_ctl.is_div = 1'b1;
        u_ctl.a = {18'd0, dth_mag, 14'd0};
        u_ctl.b = qwo_pkg::TWO_PI_DIV;
      end
      S_MULX: begin
        u_ctl.a = {31'd0, sum_mag};
        u_ctl.b = {1'b0, c_mag};
      end
      S_MULY: begin
        u_ctl.a = {31'd0, sum_mag};
        u_ctl.b = {1'b0, s_mag};
      end
      S_VMUL: begin
        u_ctl.a = {32'd0, v_mag};
        u_ctl.b = qwo_pkg::MS_PER_S;
      end
      S_VDIV: begin
        u_ctl.is_div = 1'b1;
        u_ctl.a = p_r + {33'd0, el_r[31:1]};
        u_ctl.b = {1'b0, el_r};
      end
      default: op_state = 1'b0;
    endcase
    launch = op_state && !wait_r;
    u_ctl.start = launch;
  end

  logic done_cap;
  assign done_cap = wait_r && u_sts.done;

  // CORDIC rotation step and other narrow helpers.
  logic signed [ZW-1:0] sx, sy, at;
  logic [63:0]          wacc, wd;
  logic [63:0]          pround;
  logic signed [32:0]   head33;
  logic                 px_neg, py_neg;

  always_comb begin
    sx     = x_r >>> k_r;
    sy     = y_r >>> k_r;
    at     = $signed({6'd0, qwo_pkg::ATAN_Q30[k_r]});
    wacc   = t1_r + q_r;
    wd     = big_r ? 64'h8000_0000 : ((wacc + 64'h1000_0000) >> 29);
    pround = (u_sts.res + 64'h4000_0000) >> 31;
    head33 = {head_r[31], head_r} + {dth_r[31], dth_r};
    px_neg = sum33[32] ^ c_val[ZW-1];
    py_neg = sum33[32] ^ y_r[ZW-1];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (upd_beat) state_nxt = S_WMUL1;
      S_WMUL1: if (done_cap) state_nxt = S_WDIV1;
      S_WDIV1: if (done_cap) state_nxt = (u_sts.res[63:31] != '0) ? S_WFIN : S_WMUL2;
      S_WMUL2: if (done_cap) state_nxt = S_WMUL3;
      S_WMUL3: if (done_cap) state_nxt = S_WDIV2;
      S_WDIV2: if (done_cap) state_nxt = S_WFIN;
      S_WFIN:  state_nxt = w_r ? S_DTH : S_WMUL1;
      S_DTH:   if (done_cap) state_nxt = S_RED;
      S_RED:   if (done_cap) state_nxt = S_WRAP;
      S_WRAP:  state_nxt = S_FOLD;
      S_FOLD:  state_nxt = S_COR;
      S_COR:   if (itc_r == ITW'(CORDIC_ITERS - 1)) state_nxt = S_MULX;
      S_MULX:  if (done_cap) state_nxt = S_MULY;
      S_MULY:  if (done_cap) state_nxt = S_HEAD;
      S_HEAD:  state_nxt = (el_r == '0) ? S_OUT : S_VMUL;
      S_VMUL:  if (done_cap) state_nxt = S_VDIV;
      S_VDIV:  if (done_cap) state_nxt = (v_r == V_Y) ? S_OUT : S_VMUL;
      S_OUT:   if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= 1'b0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (launch) begin
        wait_r <= 1'b1;
      end else if (done_cap) begin
        wait_r <= 1'b0;
      end
      if (state_r == S_HEAD) begin
        if (head33[32] != head33[31]) begin
          head_r <= head33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          head_r <= head33[31:0];
        end
      end
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (upd_beat) begin
          rsnap_r <= right_cnt_r;
          lsnap_r <= left_cnt_r;
          el_r    <= in_data.elapsed_ms;
          w_r     <= 1'b0;
        end
      end
      S_WMUL1, S_WMUL3: if (done_cap) p_r <= u_sts.res;
      S_WDIV1: begin
        if (done_cap) begin
          q_r   <= u_sts.res;
          r_r   <= u_sts.rem;
          big_r <= u_sts.res[63:31] != '0;
        end
      end
      S_WMUL2: if (done_cap) t1_r <= u_sts.res;
      S_WDIV2: if (done_cap) q_r <= u_sts.res;
      S_WFIN: begin
        if (w_r) begin
          ld_r <= qwo_pkg::sat32(cnt_sel[CW-1], wd);
        end else begin
          rd_r <= qwo_pkg::sat32(cnt_sel[CW-1], wd);
        end
        w_r <= 1'b1;
      end
      S_DTH: if (done_cap) dth_r <= qwo_pkg::sat32(diff33[32], u_sts.res);
      S_RED: begin
        // Remainder takes the sign of the angle, as a truncating modulo does.
        if (done_cap) begin
          z_r <= dth_r[31] ? -$signed({3'd0, u_sts.rem}) : $signed({3'd0, u_sts.rem});
        end
      end
      S_WRAP: begin
        if (z_r[ZW-1]) begin
          if (z_r < -qwo_pkg::Z_PI) z_r <= z_r + qwo_pkg::Z_TWO_PI;
        end else if (z_r >= qwo_pkg::Z_PI) begin
          z_r <= z_r - qwo_pkg::Z_TWO_PI;
        end
      end
      S_FOLD: begin
        x_r    <= qwo_pkg::Z_GAIN;
        y_r    <= '0;
        k_r    <= '0;
        itc_r  <= '0;
        flip_r <= 1'b0;
        if (z_r > qwo_pkg::Z_HALF_PI) begin
          z_r    <= qwo_pkg::Z_PI - z_r;
          flip_r <= 1'b1;
        end else if (z_r < -qwo_pkg::Z_HALF_PI) begin
          z_r    <= -qwo_pkg::Z_PI - z_r;
          flip_r <= 1'b1;
        end
      end
      S_COR: begin
        if (!z_r[ZW-1]) begin
          x_r <= x_r - sy;
          y_r <= y_r + sx;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + sy;
          y_r <= y_r - sx;
          z_r <= z_r + at;
        end
        k_r   <= k_r + 1'b1;
        itc_r <= itc_r + 1'b1;
      end
      S_MULX: if (done_cap) px_r <= qwo_pkg::sat32(px_neg, pround);
      S_MULY: if (done_cap) py_r <= qwo_pkg::sat32(py_neg, pround);
      S_HEAD: begin
        v_r    <= V_TURN;
        zero_r <= el_r == '0;
        vth_r  <= '0;
        vx_r   <= '0;
        vy_r   <= '0;
      end
      S_VMUL: if (done_cap) p_r <= u_sts.res;
      S_VDIV: begin
        if (done_cap) begin
          case (v_r)
            V_TURN:  vth_r <= qwo_pkg::sat32(v_src[31], u_sts.res);
            V_X:     vx_r  <= qwo_pkg::sat32(v_src[31], u_sts.res);
            default: vy_r  <= qwo_pkg::sat32(v_src[31], u_sts.res);
          endcase
          v_r <= v_r + 2'd1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_data_r.right_dist_um <= rd_r;
          out_data_r.left_dist_um  <= ld_r;
          out_data_r.delta_heading <= dth_r;
          out_data_r.heading       <= head_r;
          out_data_r.turn_rate     <= vth_r;
          out_data_r.disp_x_um     <= px_r;
          out_data_r.disp_y_um     <= py_r;
          out_data_r.speed_x       <= vx_r;
          out_data_r.speed_y       <= vy_r;
          out_data_r.zero_interval <= zero_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_pins_never_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_data.func |-> !in_stall)
    else $error("pin sample stalled");

  a_unit_free_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    u_ctl.start |-> !u_sts.busy)
    else $error("serial unit started while busy");

  a_counts_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    upd_beat |=> right_cnt_r == '0 && left_cnt_r == '0)
    else $error("counters not cleared by update");

  a_one_wait: assert property (@(posedge clk) disable iff (!rst_n)
    u_sts.done |-> wait_r)
    else $error("serial result with no request pending");
`endif

endmodule

[hw/rtl/qwo_serial.sv]
`timescale 1ns / 1ps

// Shared bit-serial unit: shift-add multiply (one multiplier bit a cycle)
// and restoring divide (one quotient bit a cycle).
module qwo_serial (
  input  logic              clk,
  input  logic              rst_n,
  input  qwo_pkg::su_ctl_t  ctl,
  output qwo_pkg::su_sts_t  sts
);

  localparam logic [qwo_pkg::STEP_W-1:0] MUL_LAST = qwo_pkg::STEP_W'(qwo_pkg::MUL_STEPS - 1);
  localparam logic [qwo_pkg::STEP_W-1:0] DIV_LAST = qwo_pkg::STEP_W'(qwo_pkg::DIV_STEPS - 1);

  logic                       busy_r;
  logic                       done_r;
  logic                       div_r;
  logic [qwo_pkg::STEP_W-1:0] cnt_r;
  logic [63:0]                acc_r;
  logic [63:0]                opa_r;
  logic [32:0]                opb_r;
  logic [32:0]                rem_r;

  logic [33:0] trial;
  logic [33:0] diff;
  logic        fits;
  logic        last;

  always_comb begin
    trial = {rem_r, acc_r[63]};
    diff  = trial - {1'b0, opb_r};
    fits  = trial >= {1'b0, opb_r};
    last  = cnt_r == (div_r ? DIV_LAST : MUL_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        div_r  <= ctl.is_div;
        cnt_r  <= '0;
        opb_r  <= ctl.b;
        if (ctl.is_div) begin
          acc_r <= ctl.a;
          rem_r <= '0;
        end else begin
          acc_r <= '0;
          opa_r <= ctl.a;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (div_r) begin
          // The dividend shifts out at the top while quotient bits enter below.
          rem_r <= fits ? diff[32:0] : trial[32:0];
          acc_r <= {acc_r[62:0], fits};
        end else begin
          if (opb_r[0]) begin
            acc_r <= acc_r + opa_r;
          end
          opa_r <= {opa_r[62:0], 1'b0};
          opb_r <= {1'b0, opb_r[32:1]};
        end
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.res  = acc_r;
  assign sts.rem  = rem_r;

endmodule
